/* sv/arcpip_pkg.sv */
// Package for the arc/line contour point-inside block.
// Sequencer states, product indexes and the shared multiply-accumulate
// control and status types. No dependencies.
`timescale 1ns / 1ps

package arcpip_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_DECIDE
    } arcpip_state_t;

    // product index inside one edge transaction
    localparam logic [1:0] PROD_FIRST     = 2'd0;
    localparam logic [1:0] PROD_SQ_DIFF   = 2'd1;  // arc: r*r - dx*dx done after this one
    localparam logic [1:0] PROD_LINE_LAST = 2'd1;
    localparam logic [1:0] PROD_ARC_LAST  = 2'd2;

    typedef struct packed {
        logic clear;     // zero the accumulator
        logic load;      // take operands, start a product
        logic subtract;  // subtract the product instead of adding it
    } arcpip_mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic acc_neg;
        logic acc_pos;
    } arcpip_mac_stat_t;

endpackage

/* sv/arcpip_mac.sv */
// Shared signed multiply-accumulate unit: one product in four limb steps.
// Each limb product is registered before it is added to the accumulator.
// Depends on arcpip_pkg.
`timescale 1ns / 1ps

module arcpip_mac #(
    parameter int OP_BITS  = 33,
    parameter int ACC_BITS = 67
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  arcpip_pkg::arcpip_mac_ctrl_t   ctrl,
    input  logic signed [OP_BITS-1:0]      op_a,
    input  logic signed [OP_BITS-1:0]      op_b,
    output arcpip_pkg::arcpip_mac_stat_t   stat
);
    import arcpip_pkg::*;

    localparam int H = (OP_BITS + 1) / 2;

    logic [OP_BITS-1:0]  ua_reg, ub_reg;
    logic                neg_reg;
    logic [1:0]          cnt_reg;
    logic                issue_reg;
    logic                pp_vld_reg;
    logic [2*H-1:0]      pp_reg;
    logic [1:0]          sh_reg;
    logic [ACC_BITS-1:0] acc_reg;

    logic [OP_BITS-1:0]  mag_a, mag_b;
    logic [H-1:0]        la, lb;
    logic [ACC_BITS-1:0] addend, term;

    assign mag_a = op_a[OP_BITS-1] ? (~op_a + OP_BITS'(1)) : op_a;
    assign mag_b = op_b[OP_BITS-1] ? (~op_b + OP_BITS'(1)) : op_b;

    assign la = cnt_reg[1] ? H'(ua_reg[OP_BITS-1:H]) : ua_reg[H-1:0];
    assign lb = cnt_reg[0] ? H'(ub_reg[OP_BITS-1:H]) : ub_reg[H-1:0];

    always_comb begin
        unique case (sh_reg)
            2'd0:    addend = ACC_BITS'(pp_reg);
            2'd1:    addend = ACC_BITS'({pp_reg, {H{1'b0}}});
            default: addend = ACC_BITS'({pp_reg, {(2*H){1'b0}}});
        endcase
        term = neg_reg ? (~addend + ACC_BITS'(1)) : addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg  <= 1'b0;
            pp_vld_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (ctrl.load) begin
                issue_reg <= 1'b1;
                cnt_reg   <= 2'd0;
            end else if (issue_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    issue_reg <= 1'b0;
                end
            end
            pp_vld_reg <= issue_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            ua_reg  <= mag_a;
            ub_reg  <= mag_b;
            neg_reg <= op_a[OP_BITS-1] ^ op_b[OP_BITS-1] ^ ctrl.subtract;
        end
        if (issue_reg) begin
            pp_reg <= la * lb;
            sh_reg <= {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]};
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (pp_vld_reg) begin
            acc_reg <= acc_reg + term;
        end
    end

    assign stat.busy    = issue_reg | pp_vld_reg;
    assign stat.acc_neg = acc_reg[ACC_BITS-1];
    assign stat.acc_pos = ~acc_reg[ACC_BITS-1] & (|acc_reg);

endmodule

/* sv/arc_polygon_point_inside.sv */
// Top level: point-inside test over a contour of lines and half-circle arcs.
// Crossing parity over one edge per transaction; uses arcpip_pkg, arcpip_mac.
//
//   channel  dir  signals                     payload
//   s_axis   in   tvalid tready tdata tuser   one edge plus the query point
//                 tlast                       tlast = last edge of contour
//   m_axis   out  tvalid tready tdata         crossing parity on last edge
//
// A line edge takes 2 products, an arc edge 3: an accept, then per product
// a load, 4 limb steps, a final add and a done check on the shared limb
// multiplier, and at the end a decision.
// A pending result sits in the output register while the next edges run;
// only a last edge finding that register still full waits for m_axis_tready.
// Synchronous active-low reset clears parity, sequencer and output valid.
`timescale 1ns / 1ps

module arc_polygon_point_inside #(
    parameter int COORD_BITS = 32
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y, circle_x, circle_y,
    // circle_radius, zero fill
    input  logic [((9*COORD_BITS-1+7)/8)*8-1:0]         s_axis_tdata,
    // is_arc, counterclockwise
    input  logic [1:0]                                  s_axis_tuser,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // inside_res, zero fill
    output logic [7:0]                                  m_axis_tdata
);
    import arcpip_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int OPW = W + 1;
    localparam int ACW = 2 * W + 3;

    arcpip_state_t state_reg, state_next;

    logic signed [W-1:0] px_reg, py_reg, sx_reg, sy_reg, ex_reg, ey_reg, cx_reg, cy_reg;
    logic [W-2:0]        r_reg;
    logic                arc_reg, ccw_reg, last_reg;
    logic [1:0]          prod_reg;
    logic                s_neg_reg;
    logic                parity_reg;
    logic                out_vld_reg;
    logic                res_reg;

    arcpip_mac_ctrl_t         mac_ctrl;
    arcpip_mac_stat_t         mac_stat;
    logic signed [OPW-1:0]    op_a, op_b;
    logic                     s_accept;
    logic [1:0]               prod_last;
    logic                     in_span, s_lt_e, e_lt_s, e_neg, upper, above, parity_new;

    function automatic logic signed [W:0] sdiff(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        sdiff = {a[W-1], a} - {b[W-1], b};
    endfunction

    assign s_accept  = s_axis_tvalid & s_axis_tready;
    assign prod_last = arc_reg ? PROD_ARC_LAST : PROD_LINE_LAST;

    // operand selection for the shared unit
    always_comb begin
        op_a = sdiff(sy_reg, py_reg);
        op_b = sdiff(ex_reg, sx_reg);
        if (arc_reg) begin
            unique case (prod_reg)
                PROD_FIRST: begin
                    op_a = {2'b00, r_reg};
                    op_b = {2'b00, r_reg};
                end
                PROD_SQ_DIFF: begin
                    op_a = sdiff(px_reg, cx_reg);
                    op_b = sdiff(px_reg, cx_reg);
                end
                default: begin
                    op_a = sdiff(py_reg, cy_reg);
                    op_b = sdiff(py_reg, cy_reg);
                end
            endcase
        end else if (prod_reg != PROD_FIRST) begin
            op_a = sdiff(px_reg, sx_reg);
            op_b = sdiff(ey_reg, sy_reg);
        end
    end

    // edge decision from the final accumulator
    assign s_lt_e  = sx_reg < ex_reg;
    assign e_lt_s  = ex_reg < sx_reg;
    assign in_span = s_lt_e ? (px_reg >= sx_reg && px_reg < ex_reg)
                            : (px_reg >= ex_reg && px_reg < sx_reg);
    assign e_neg   = py_reg < cy_reg;
    assign upper   = ccw_reg == e_lt_s;

    always_comb begin
        if (!in_span) begin
            above = 1'b0;
        end else if (!arc_reg) begin
            above = s_lt_e ? mac_stat.acc_pos : mac_stat.acc_neg;
        end else if (upper) begin
            above = e_neg | mac_stat.acc_pos;
        end else begin
            above = e_neg & (s_neg_reg | mac_stat.acc_neg);
        end
    end

    assign parity_new = parity_reg ^ above;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_WAIT;
            ST_WAIT: begin
                if (!mac_stat.busy) begin
                    state_next = (prod_reg == prod_last) ? ST_DECIDE : ST_LOAD;
                end
            end
            ST_DECIDE: begin
                if (!last_reg || !out_vld_reg || m_axis_tready) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready     = state_reg == ST_IDLE;
        mac_ctrl.clear    = s_accept;
        mac_ctrl.load     = state_reg == ST_LOAD;
        mac_ctrl.subtract = arc_reg & (prod_reg != PROD_FIRST);
        m_axis_tvalid     = out_vld_reg;
        m_axis_tdata      = {7'd0, res_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            parity_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            prod_reg    <= PROD_FIRST;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                prod_reg <= PROD_FIRST;
            end else if (state_reg == ST_WAIT && !mac_stat.busy && prod_reg != prod_last) begin
                prod_reg <= prod_reg + 2'd1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (state_reg == ST_DECIDE && state_next == ST_IDLE) begin
                if (last_reg) begin
                    out_vld_reg <= 1'b1;
                    parity_reg  <= 1'b0;
                end else begin
                    parity_reg  <= parity_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg   <= s_axis_tdata[0*W +: W];
            py_reg   <= s_axis_tdata[1*W +: W];
            sx_reg   <= s_axis_tdata[2*W +: W];
            sy_reg   <= s_axis_tdata[3*W +: W];
            ex_reg   <= s_axis_tdata[4*W +: W];
            ey_reg   <= s_axis_tdata[5*W +: W];
            cx_reg   <= s_axis_tdata[6*W +: W];
            cy_reg   <= s_axis_tdata[7*W +: W];
            r_reg    <= s_axis_tdata[8*W +: W-1];
            arc_reg  <= s_axis_tuser[0];
            ccw_reg  <= s_axis_tuser[1];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_WAIT && !mac_stat.busy && prod_reg == PROD_SQ_DIFF) begin
            s_neg_reg <= mac_stat.acc_neg;
        end
        if (state_reg == ST_DECIDE && state_next == ST_IDLE && last_reg) begin
            res_reg <= parity_new;
        end
    end

    arcpip_mac #(
        .OP_BITS  (OPW),
        .ACC_BITS (ACW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (op_a),
        .op_b    (op_b),
        .stat    (mac_stat)
    );

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_LOAD)
        else $error("accepted edge did not start a product");

    a_decide_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DECIDE |-> !mac_stat.busy)
        else $error("decision taken while multiplier busy");

    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DECIDE && last_reg))
        else $error("result raised outside a last-edge decision");

    a_parity_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && state_next == ST_IDLE && last_reg) |=> !parity_reg)
        else $error("parity not cleared after last edge");

endmodule

/* tb/arc_polygon_point_inside_check.sv */
// Checker for arc_polygon_point_inside: watches both stream channels, keeps its
// own crossing parity per contour and compares each result in order.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps

module arc_polygon_point_inside_check #(
    parameter int CB     = 32,
    parameter int DATA_W = ((9*CB-1+7)/8)*8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    output int                fail_count,
    output int                results_pending
);

    typedef logic signed [127:0] wide_t;

    localparam int F_PX = 0, F_PY = 1, F_SX = 2, F_SY = 3, F_EX = 4, F_EY = 5;
    localparam int F_CX = 6, F_CY = 7, F_R = 8;
    localparam int USER_ARC = 0, USER_CCW = 1;

    logic inside_queue[$];
    logic parity;

    initial begin
        fail_count = 0;
        results_pending = 0;
    end

    function automatic wide_t coord(input logic [DATA_W-1:0] d, input int idx);
        logic [CB-1:0] c;
        c = d[idx*CB +: CB];
        return {{(128-CB){c[CB-1]}}, c};
    endfunction

    function automatic logic edge_crosses(input logic [DATA_W-1:0] d, input logic [1:0] u);
        wide_t px, py, sx, sy, ex, ey, cx, cy, r;
        wide_t lo, hi, span, dx, e, s, e2;
        logic upper;
        px = coord(d, F_PX);
        py = coord(d, F_PY);
        sx = coord(d, F_SX);
        sy = coord(d, F_SY);
        ex = coord(d, F_EX);
        ey = coord(d, F_EY);
        cx = coord(d, F_CX);
        cy = coord(d, F_CY);
        r  = {{(128-CB+1){1'b0}}, d[F_R*CB +: CB-1]};
        lo = (sx < ex) ? sx : ex;
        hi = (sx < ex) ? ex : sx;
        if (px < lo || px >= hi)
            return 1'b0;
        if (!u[USER_ARC]) begin
            span = ex - sx;
            s = (sy - py) * span + (px - sx) * (ey - sy);
            return (span > 0) ? (s > 0) : (s < 0);
        end
        upper = (u[USER_CCW] == (ex < sx));
        dx = px - cx;
        e  = py - cy;
        s  = r * r - dx * dx;
        e2 = e * e;
        if (upper)
            return (e < 0) || (e2 < s);
        if (s < 0)
            s = 0;
        return (e < 0) && (s < e2);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic flipped;
        logic want;
        if (!aresetn) begin
            parity <= 1'b0;
            inside_queue.delete();
            results_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (inside_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transaction, inside_res=%0b",
                                              m_tdata[0]));
                end else begin
                    want = inside_queue.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch($sformatf("inside_res: got %0b, expected %0b",
                                                  m_tdata[0], want));
                end
            end
            if (s_tvalid && s_tready) begin
                flipped = parity ^ edge_crosses(s_tdata, s_tuser);
                if (s_tlast) begin
                    inside_queue = {inside_queue, flipped};
                    parity <= 1'b0;
                end else begin
                    parity <= flipped;
                end
            end
            results_pending <= inside_queue.size();
        end
    end

endmodule

/* tb/arc_polygon_point_inside_test.sv */
// Testbench top for arc_polygon_point_inside: clock, reset, contour stimulus
// and result back-pressure; checking lives in arc_polygon_point_inside_check.
`timescale 1ns / 1ps

module arc_polygon_point_inside_test;

    localparam int COORD_BITS   = 32;
    localparam int DATA_W       = ((9*COORD_BITS-1+7)/8)*8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_EDGES = 1680;

    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;
    localparam logic [30:0]        R_MAX = 31'h7fff_ffff;

    typedef struct {
        logic signed [31:0] px, py, sx, sy, ex, ey, cx, cy;
        logic [30:0]        r;
        logic               is_arc;
        logic               ccw;
        logic               last;
    } edge_item_t;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // px, py, sx, sy, ex, ey, cx, cy, radius, zero fill
    logic [1:0]        s_axis_tuser;   // is_arc, counterclockwise
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // inside_res, zero fill

    int fail_count;
    int results_pending;
    int burst_left = 0;
    int cycle_count = 0;

    arc_polygon_point_inside #(.COORD_BITS(COORD_BITS)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    arc_polygon_point_inside_check #(.CB(COORD_BITS), .DATA_W(DATA_W)) parity_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .s_tlast         (s_axis_tlast),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer(input edge_item_t it);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.r, it.cy, it.cx, it.ey, it.ex, it.sy, it.sx, it.py, it.px};
        s_axis_tuser  <= {it.ccw, it.is_arc};
        s_axis_tlast  <= it.last;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_edge(input logic signed [31:0] px, py, sx, sy, ex, ey, cx, cy,
                             input logic [30:0] r, input logic is_arc, ccw, last);
        edge_item_t it;
        it = '{px, py, sx, sy, ex, ey, cx, cy, r, is_arc, ccw, last};
        offer(it);
    endtask

    // sender stops until every result it caused has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_contour(output int sent);
        edge_item_t it;
        logic signed [31:0] vx[16];
        logic signed [31:0] vy[16];
        int n, spread, k, nxt;
        real half, ddx, ddy;
        logic open_end;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        spread = $urandom_range(2, 31);
        open_end = ($urandom_range(0, 9) == 0);
        it.px = $urandom;
        it.py = $urandom;
        if ($urandom_range(0, 7) != 0) begin
            it.px = it.px >>> 11;
            it.py = it.py >>> 11;
        end
        for (k = 0; k < n; k++) begin
            vx[k] = it.px + ($signed($urandom) >>> (32 - spread));
            vy[k] = it.py + ($signed($urandom) >>> (32 - spread));
            if ($urandom_range(0, 7) == 0)
                vx[k] = it.px;
            if ($urandom_range(0, 7) == 0)
                vy[k] = it.py;
        end
        for (k = 0; k < n; k++) begin
            nxt = (k + 1) % n;
            it.sx = vx[k];
            it.sy = vy[k];
            it.ex = vx[nxt];
            it.ey = vy[nxt];
            if (open_end && k == n - 1) begin
                it.ex = $urandom;
                it.ey = $urandom;
            end
            it.is_arc = ($urandom_range(0, 4) < 2);
            it.ccw = 1'($urandom);
            it.last = (k == n - 1);
            it.cx = $urandom;
            it.cy = $urandom;
            it.r = 31'($urandom);
            if (it.is_arc) begin
                it.cx = 32'((longint'(it.sx) + longint'(it.ex)) >>> 1);
                it.cy = 32'((longint'(it.sy) + longint'(it.ey)) >>> 1);
                ddx = real'(longint'(it.ex) - longint'(it.sx));
                ddy = real'(longint'(it.ey) - longint'(it.sy));
                half = $sqrt(ddx * ddx + ddy * ddy) / 2.0;
                if (half > 2147483647.0)
                    half = 2147483647.0;
                it.r = 31'($rtoi(half));
                case ($urandom_range(0, 5))
                    0: it.r = 31'($urandom);
                    1: it.r = 31'(it.r + $urandom_range(0, 4));
                    2: it.cy = it.cy + ($signed($urandom) >>> (32 - spread));
                    default: ;
                endcase
            end
            if ($urandom_range(0, 11) == 0) begin
                it.px = $urandom;
                it.py = $urandom;
                it.sx = $urandom;
                it.sy = $urandom;
                it.ex = $urandom;
                it.ey = $urandom;
                it.cx = $urandom;
                it.cy = $urandom;
                it.r  = 31'($urandom);
            end
            offer(it);
        end
        sent = n;
    endtask

    // receiver: random stall patterns, one long hold-off early in the random part
    initial begin
        int stretch, mode, cycles;
        logic held;
        m_axis_tready <= 1'b0;
        cycles = 0;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            stretch = $urandom_range(5, 60);
            mode = $urandom_range(0, 3);
            repeat (stretch) begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge aclk);
                cycles++;
            end
            if (!held && cycles > 4000) begin
                m_axis_tready <= 1'b0;
                repeat (1500) @(posedge aclk);
                held = 1'b1;
            end
        end
    end

    initial begin
        int edges_sent, contours, sent;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // lines: both x directions, empty spans, span ends, on-line point, extremes
        send_edge(0, 0, -10, 5, 10, 5, 0, 0, 0, 0, 0, 0);
        send_edge(0, 0, 10, -5, -10, -5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, 10, 5, -10, 5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, 0, -5, 0, 5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, 0, 5, 0, 5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, 0, 5, 10, 5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, -10, 5, 0, 5, 0, 0, 0, 0, 0, 1);
        send_edge(0, 0, -10, 0, 10, 0, 0, 0, 0, 0, 0, 1);
        send_edge(0, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, R_MAX, 0, 1, 1);
        send_edge(C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, 0, 0, 0, 0, 0, 1);
        send_edge(C_MAX, 0, C_MIN, 5, C_MAX, 5, 0, 0, 0, 0, 0, 1);
        // arcs: every sweep/direction pair, upper and lower branches, ties,
        // point beyond the circle, full-scale radius
        send_edge(3, 2, 10, 0, -10, 0, 0, 0, 10, 1, 1, 1);
        send_edge(3, 2, -10, 0, 10, 0, 0, 0, 10, 1, 0, 1);
        send_edge(3, -9, -10, 0, 10, 0, 0, 0, 10, 1, 1, 0);
        send_edge(3, -10, -10, 0, 10, 0, 0, 0, 10, 1, 1, 1);
        send_edge(3, -2, 10, 0, -10, 0, 0, 0, 10, 1, 0, 1);
        send_edge(3, 4, 5, 0, -5, 0, 0, 0, 5, 1, 1, 1);
        send_edge(3, -4, -5, 0, 5, 0, 0, 0, 5, 1, 1, 1);
        send_edge(3, 0, 10, 0, -10, 0, 0, 0, 10, 1, 1, 1);
        send_edge(15, -1, -20, 0, 20, 0, 0, 0, 10, 1, 1, 1);
        send_edge(15, 1, 20, 0, -20, 0, 0, 0, 10, 1, 1, 1);
        send_edge(0, C_MAX, C_MIN, 0, C_MAX, 0, 0, 0, R_MAX, 1, 0, 1);
        send_edge(0, C_MIN, C_MIN, 0, C_MAX, 0, 0, 0, R_MAX, 1, 0, 1);
        wait_for_results();

        edges_sent = 0;
        contours = 0;
        while (edges_sent < RANDOM_EDGES) begin
            send_contour(sent);
            edges_sent += sent;
            contours++;
            if (contours == 60)
                wait_for_results();
        end
        wait_for_results();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
